>>> rtl/wrw_pkg.sv
`default_nettype none
package wrw_pkg;

  // Field widths fixed by the item format
  localparam int CMD_W     = 2;
  localparam int SLOT_W    = 7;
  localparam int IN_WGT_W  = 32;
  localparam int FRAC_W    = 16;
  localparam int COUNT_W   = 8;
  localparam int STEP_W    = COUNT_W + 2;  // holds 4 * count
  localparam int FRAC_SHR  = FRAC_W - 1;   // Q0.16 times 2.0

  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;
  localparam int REG_PARTICLE_COUNT = 0;

  localparam int MAX_PARTICLES_DEF = 128;
  localparam int WEIGHT_BITS_DEF   = 32;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(100);

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_DRAW  = 2'd2
  } cmd_t;

  // controller -> datapath
  typedef struct packed {
    logic do_begin;
    logic do_load;
    logic do_mul;
    logic do_prep;   // add increment, clamp wheel, read first weight
    logic do_step;   // take one wheel step
    logic out_load;  // capture selected slot into output register
  } wrw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_go;
  } wrw_sts_t;

endpackage
`default_nettype wire

>>> rtl/wrw_in_if.sv
`default_nettype none
interface wrw_in_if
  import wrw_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [SLOT_W-1:0]   slot;
  logic [IN_WGT_W-1:0] weight;
  logic [FRAC_W-1:0]   rand_fraction;

  modport source (output valid, cmd, slot, weight, rand_fraction, input ready);
  modport sink   (input valid, cmd, slot, weight, rand_fraction, output ready);
endinterface
`default_nettype wire

>>> rtl/wrw_out_if.sv
`default_nettype none
interface wrw_out_if
  import wrw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] selected_slot;

  modport source (output valid, selected_slot, input ready);
  modport sink   (input valid, selected_slot, output ready);
endinterface
`default_nettype wire

>>> rtl/wrw_ram.sv
`default_nettype none
module wrw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/wrw_ctrl.sv
`default_nettype none
module wrw_ctrl
  import wrw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [CMD_W-1:0] in_cmd,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire wrw_sts_t         sts,
  output wrw_cmd_t              cmd_o
);
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_WALK,
    ST_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, out_valid_r;
  logic   accept, out_free;

  assign accept   = in_valid && in_ready_r;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_BEGIN: cmd_o.do_begin = 1'b1;
            CMD_LOAD:  cmd_o.do_load  = 1'b1;
            CMD_DRAW: begin
              cmd_o.do_mul = 1'b1;
              state_nxt    = ST_PREP;
            end
            default: ;
          endcase
        end
      end
      ST_PREP: begin
        cmd_o.do_prep = 1'b1;
        state_nxt     = ST_WALK;
      end
      ST_WALK: begin
        if (sts.walk_go) begin
          cmd_o.do_step = 1'b1;
        end else if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
      if (cmd_o.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_draw_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_DRAW) |=> (state_r == ST_PREP))
    else $error("draw transfer did not start a walk");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.out_load |=> out_valid_r)
    else $error("result capture lost");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> (state_r == ST_IDLE))
    else $error("input ready outside idle");
`endif
endmodule
`default_nettype wire

>>> rtl/wrw_dp.sv
`default_nettype none
module wrw_dp
  import wrw_pkg::*;
#(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire wrw_cmd_t            cmd,
  output wrw_sts_t                 sts,
  input  wire logic [SLOT_W-1:0]   in_slot,
  input  wire logic [IN_WGT_W-1:0] in_weight,
  input  wire logic [FRAC_W-1:0]   in_frac,
  input  wire logic                cfg_we,
  input  wire logic [COUNT_W-1:0]  cfg_wdata,
  output logic      [COUNT_W-1:0]  count,
  output logic      [SLOT_W-1:0]   sel_slot
);
  localparam int AW     = $clog2(MAX_PARTICLES);
  localparam int BW     = WEIGHT_BITS + 2;
  localparam int PROD_W = WEIGHT_BITS + FRAC_W;
  localparam int INC_W  = PROD_W - FRAC_SHR;

  logic [COUNT_W-1:0]     count_r;
  logic [WEIGHT_BITS-1:0] max_r;
  logic [BW-1:0]          beta_r;
  logic [COUNT_W-1:0]     pos_r;
  logic [STEP_W-1:0]      steps_r;
  logic [PROD_W-1:0]      prod_r;
  logic [SLOT_W-1:0]      sel_r;

  logic [COUNT_W-1:0]     cnt_eff, pos_start, pos_inc, slot_ext;
  logic [COUNT_W:0]       pos_p1;
  logic [STEP_W-1:0]      limit;
  logic [WEIGHT_BITS-1:0] wgt_in, rdata;
  logic [INC_W-1:0]       inc;
  logic [BW:0]            beta_sum;
  logic [BW-1:0]          beta_sat;
  logic                   slot_ok;

  always_comb begin
    cnt_eff = count_r;
    if (count_r == '0) begin
      cnt_eff = COUNT_W'(1);
    end else if (32'(count_r) > 32'(MAX_PARTICLES)) begin
      cnt_eff = COUNT_W'(MAX_PARTICLES);
    end
  end

  assign limit     = {cnt_eff, 2'b00};
  assign pos_start = (pos_r >= cnt_eff) ? '0 : pos_r;
  assign pos_p1    = {1'b0, pos_r} + (COUNT_W+1)'(1);
  assign pos_inc   = (pos_p1 < {1'b0, cnt_eff}) ? pos_p1[COUNT_W-1:0] : '0;
  assign slot_ext  = COUNT_W'(in_slot);
  assign slot_ok   = 32'(in_slot) < 32'(MAX_PARTICLES);
  assign wgt_in    = WEIGHT_BITS'(in_weight);

  // beta += (frac * max) >> 15, saturated
  assign inc      = prod_r[PROD_W-1:FRAC_SHR];
  assign beta_sum = (BW+1)'(beta_r) + (BW+1)'(inc);
  assign beta_sat = beta_sum[BW] ? '1 : beta_sum[BW-1:0];

  assign sts.walk_go = (steps_r < limit) && (beta_r > BW'(rdata));

  wrw_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_PARTICLES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.do_load && slot_ok),
    .waddr (AW'(in_slot)),
    .wdata (wgt_in),
    .raddr (AW'(cmd.do_prep ? pos_start : pos_inc)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
      max_r   <= '0;
      beta_r  <= '0;
      pos_r   <= '0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      if (cmd.do_begin) begin
        max_r  <= '0;
        beta_r <= '0;
        pos_r  <= (slot_ext < cnt_eff) ? slot_ext : '0;
      end
      if (cmd.do_load && slot_ok && (wgt_in > max_r)) begin
        max_r <= wgt_in;
      end
      if (cmd.do_prep) begin
        beta_r <= beta_sat;
        pos_r  <= pos_start;
      end
      if (cmd.do_step) begin
        beta_r <= beta_r - BW'(rdata);
        pos_r  <= pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_mul) begin
      prod_r <= PROD_W'(in_frac) * PROD_W'(max_r);
    end
    if (cmd.do_prep) begin
      steps_r <= '0;
    end else if (cmd.do_step) begin
      steps_r <= steps_r + STEP_W'(1);
    end
    if (cmd.out_load) begin
      sel_r <= pos_r[SLOT_W-1:0];
    end
  end

  assign count    = count_r;
  assign sel_slot = sel_r;

`ifndef NO_ASSERTIONS
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_step |-> (steps_r < limit))
    else $error("wheel walk ran past its step limit");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_step || cmd.out_load) |-> (pos_r < cnt_eff))
    else $error("wheel position outside particle ring");
  // a zero weight under the wheel leaves beta unchanged
  a_beta_drops: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_step |=> (beta_r <= $past(beta_r)))
    else $error("beta rose on a wheel step");
`endif
endmodule
`default_nettype wire

>>> rtl/weighted_resampling_wheel_core.sv
`default_nettype none
// Sequencing: begin and load transfers are taken in the idle state; a draw runs from its
//   input transfer through multiply, add/clamp and k wheel steps (k <= 4 * count, count
//   clamped to 1..MAX_PARTICLES) to the result in the output register.
// Throughput: one item in flight; the walk loop takes one weight-store read per cycle.
// Reset (rst_n, synchronous, active low): particle_count = 100, max/beta/wheel = 0,
//   controller idle, no result pending. The weight store is not cleared.
module weighted_resampling_wheel_core
  import wrw_pkg::*;
#(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  wrw_in_if.sink                 in_ch,
  wrw_out_if.source              out_ch,
  // APB-style register port, particle_count at address 0
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);
  wrw_cmd_t           cmd;
  wrw_sts_t           sts;
  logic [COUNT_W-1:0] count;
  logic               reg_hit;
  logic               cfg_we;

  // register index is the word address
  assign reg_hit = (32'(paddr[APB_AW-1:2]) == REG_PARTICLE_COUNT);
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? APB_DW'(count) : '0;

  // Controller: sequences begin/load in the idle state, draw through
  // multiply -> add/clamp -> walk -> output register.
  wrw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd_o     (cmd)
  );

  // Datapath: weight store, running max, beta accumulator, wheel position,
  // step counter and the registered result slot.
  wrw_dp #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_slot   (in_ch.slot),
    .in_weight (in_ch.weight),
    .in_frac   (in_ch.rand_fraction),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata[COUNT_W-1:0]),
    .count     (count),
    .sel_slot  (out_ch.selected_slot)
  );
endmodule
`default_nettype wire
